FILE: rtl/core/lsrs_pkg.sv
`timescale 1ns / 1ps
// Shared codes and result type of the record store.
// No dependencies.
package lsrs_pkg;

    localparam logic [2:0] CMD_ERASE  = 3'd0;
    localparam logic [2:0] CMD_MOUNT  = 3'd1;
    localparam logic [2:0] CMD_WSTART = 3'd2;
    localparam logic [2:0] CMD_WBYTE  = 3'd3;
    localparam logic [2:0] CMD_RBYTE  = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_RECORD = 3'd1;
    localparam logic [2:0] ST_WRONG_KEY = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_ERROR     = 3'd4;

    localparam logic [7:0]  ERASED_BYTE = 8'hFF;
    localparam logic [15:0] UNUSED_KEY  = 16'hFFFF;

    typedef struct packed {
        logic [12:0] write_pos;
        logic [7:0]  data_out;
        logic [2:0]  status;
    } t_result;

endpackage

FILE: rtl/core/lsrs_ram.sv
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module lsrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;
endmodule

FILE: rtl/core/lsrs_ctrl.sv
`timescale 1ns / 1ps
// Command sequencer: erase, header walks, compaction, appends and reads.
// Depends on lsrs_pkg; drives the store, scratch and key list RAMs.
module lsrs_ctrl #(
    parameter int MEM_BYTES = 4096,
    parameter int KEY_SLOTS = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [2:0]                   i_cmd,
    input  logic [15:0]                  i_key,
    input  logic [11:0]                  i_length,
    input  logic [7:0]                   i_data_in,
    input  logic [11:0]                  i_offset,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output lsrs_pkg::t_result            o_res,
    output logic                         o_st_we,
    output logic [$clog2(MEM_BYTES)-1:0] o_st_waddr,
    output logic [7:0]                   o_st_wdata,
    output logic [$clog2(MEM_BYTES)-1:0] o_raddr,
    input  logic [7:0]                   i_st_q,
    output logic                         o_sc_we,
    output logic [$clog2(MEM_BYTES)-1:0] o_sc_waddr,
    input  logic [7:0]                   i_sc_q,
    output logic                         o_kl_we,
    output logic [$clog2(KEY_SLOTS)-1:0] o_kl_waddr,
    output logic [$clog2(KEY_SLOTS)-1:0] o_kl_raddr,
    input  logic [15:0]                  i_kl_q,
    output logic [15:0]                  o_hdr_key
);
    import lsrs_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    localparam int PW = AW + 1;
    localparam int KW = $clog2(KEY_SLOTS);
    localparam int NW = KW + 1;
    localparam int SW = ((PW > 16) ? PW : 16) + 2;
    localparam logic [SW-1:0] MEM_S  = SW'(MEM_BYTES);
    localparam logic [SW-1:0] HDR_S  = SW'(4);
    localparam logic [NW-1:0] SLOT_N = NW'(KEY_SLOTS);

    typedef enum logic [21:0] {
        S_IDLE  = 22'd1 << 0,
        S_ERASE = 22'd1 << 1,
        S_MWALK = 22'd1 << 2,
        S_MHDR  = 22'd1 << 3,
        S_HDR   = 22'd1 << 4,
        S_WCHK  = 22'd1 << 5,
        S_WHDR  = 22'd1 << 6,
        S_FWALK = 22'd1 << 7,
        S_FHDR  = 22'd1 << 8,
        S_RDONE = 22'd1 << 9,
        S_RRD   = 22'd1 << 10,
        S_RQ    = 22'd1 << 11,
        S_CCOPY = 22'd1 << 12,
        S_CWALK = 22'd1 << 13,
        S_CHDR  = 22'd1 << 14,
        S_CSRCH = 22'd1 << 15,
        S_CSCMP = 22'd1 << 16,
        S_CNEXT = 22'd1 << 17,
        S_CKEY  = 22'd1 << 18,
        S_CCP0  = 22'd1 << 19,
        S_CCPY  = 22'd1 << 20,
        S_FIN   = 22'd1 << 21
    } t_state;

    t_state r_state, n_state, r_hret, n_hret, r_fret, n_fret, r_eret, n_eret;
    logic [PW-1:0] r_pos, n_pos, r_app, n_app, r_at, n_at;
    logic [SW-1:0] r_cnt, n_cnt;
    logic [2:0]    r_hb, n_hb;
    logic [31:0]   r_hdr, n_hdr;
    logic [15:0]   r_key, n_key, r_tgt, n_tgt, r_at_len, n_at_len;
    logic [11:0]   r_len, n_len, r_off, n_off;
    logic          r_found, n_found, r_src, n_src, r_cmpd, n_cmpd;
    logic [NW-1:0] r_n, n_n, r_i, n_i, r_j, n_j;
    logic [2:0]    r_status, n_status;
    logic [7:0]    r_dout, n_dout;
    logic          r_ovalid, n_ovalid;
    t_result       r_res, n_res;

    logic [7:0]    rdata;
    logic [15:0]   hdr_key, hdr_len;
    logic [SW-1:0] pos_s, rec_end, at_size, cnt_m1, rd_hdr, rd_byte, rd_cpy, wr_cpy, wr_hdr;
    logic          hdr_fits, rec_ok, w_fits;

    always_comb begin
        rdata    = r_src ? i_sc_q : i_st_q;
        hdr_key  = r_hdr[15:0];
        hdr_len  = r_hdr[31:16];
        pos_s    = SW'(r_pos);
        hdr_fits = (pos_s + HDR_S) <= MEM_S;
        rec_end  = pos_s + HDR_S + SW'(hdr_len);
        rec_ok   = rec_end <= MEM_S;
        at_size  = HDR_S + SW'(r_at_len);
        cnt_m1   = r_cnt - SW'(1);
        w_fits   = (HDR_S + SW'(r_len)) <= (MEM_S - SW'(r_app));
        rd_hdr   = pos_s + SW'(r_hb);
        rd_byte  = SW'(r_at) + HDR_S + SW'(r_off);
        rd_cpy   = SW'(r_at) + r_cnt;
        wr_cpy   = SW'(r_app) + cnt_m1;
        wr_hdr   = SW'(r_app) + r_cnt;
    end

    always_comb begin
        n_state = r_state; n_hret = r_hret; n_fret = r_fret; n_eret = r_eret;
        n_pos = r_pos; n_app = r_app; n_at = r_at; n_cnt = r_cnt; n_hb = r_hb;
        n_hdr = r_hdr; n_key = r_key; n_tgt = r_tgt; n_at_len = r_at_len;
        n_len = r_len; n_off = r_off; n_found = r_found; n_src = r_src;
        n_cmpd = r_cmpd; n_n = r_n; n_i = r_i; n_j = r_j;
        n_status = r_status; n_dout = r_dout; n_res = r_res;
        n_ovalid = r_ovalid && !i_res_ready;
        o_st_we = 1'b0; o_st_waddr = '0; o_st_wdata = ERASED_BYTE;
        o_sc_we = 1'b0; o_sc_waddr = cnt_m1[AW-1:0];
        o_kl_we = 1'b0; o_kl_waddr = r_n[KW-1:0]; o_kl_raddr = r_j[KW-1:0];
        o_raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_key = i_key; n_len = i_length; n_off = i_offset;
                    n_status = ST_OK; n_dout = '0; n_cmpd = 1'b0;
                    n_state = S_FIN;
                    unique case (i_cmd)
                        CMD_ERASE: begin
                            n_cnt = '0; n_eret = S_FIN; n_state = S_ERASE;
                        end
                        CMD_MOUNT: begin
                            n_pos = '0; n_src = 1'b0; n_status = ST_ERROR;
                            n_state = S_MWALK;
                        end
                        CMD_WSTART: begin
                            if (i_key == UNUSED_KEY) n_status = ST_WRONG_KEY;
                            else n_state = S_WCHK;
                        end
                        CMD_WBYTE: begin
                            if (SW'(r_app) < MEM_S) begin
                                o_st_we = 1'b1; o_st_waddr = r_app[AW-1:0];
                                o_st_wdata = i_data_in;
                                n_app = r_app + PW'(1);
                            end else begin
                                n_status = ST_FULL;
                            end
                        end
                        CMD_RBYTE: begin
                            if (i_key == UNUSED_KEY) begin
                                n_status = ST_WRONG_KEY;
                            end else begin
                                n_tgt = i_key; n_found = 1'b0; n_pos = '0;
                                n_src = 1'b0; n_fret = S_RDONE; n_state = S_FWALK;
                            end
                        end
                        default: n_status = ST_ERROR;
                    endcase
                end
            end
            S_ERASE: begin
                o_st_we = 1'b1; o_st_waddr = r_cnt[AW-1:0];
                if (r_cnt == MEM_S - SW'(1)) n_state = r_eret;
                else n_cnt = r_cnt + SW'(1);
            end
            S_HDR: begin
                o_raddr = rd_hdr[AW-1:0];
                if (r_hb != 3'd0) n_hdr = {rdata, r_hdr[31:8]};
                if (r_hb == 3'd4) n_state = r_hret;
                else n_hb = r_hb + 3'd1;
            end
            S_MWALK: begin
                if (!hdr_fits) n_state = S_FIN;
                else begin n_hb = '0; n_hret = S_MHDR; n_state = S_HDR; end
            end
            S_MHDR: begin
                if (hdr_key == UNUSED_KEY) begin
                    n_app = r_pos;
                    n_status = (r_pos == '0) ? ST_NO_RECORD : ST_OK;
                    n_state = S_FIN;
                end else if (!rec_ok) begin
                    n_state = S_FIN;
                end else begin
                    n_pos = rec_end[PW-1:0]; n_state = S_MWALK;
                end
            end
            S_WCHK: begin
                if (w_fits) begin
                    n_cnt = '0; n_state = S_WHDR;
                end else if (!r_cmpd) begin
                    n_cmpd = 1'b1; n_cnt = '0; n_src = 1'b0; n_state = S_CCOPY;
                end else begin
                    n_status = ST_FULL; n_state = S_FIN;
                end
            end
            S_WHDR: begin
                o_st_we = 1'b1; o_st_waddr = wr_hdr[AW-1:0];
                case (r_cnt[1:0])
                    2'd0:    o_st_wdata = r_key[7:0];
                    2'd1:    o_st_wdata = r_key[15:8];
                    2'd2:    o_st_wdata = r_len[7:0];
                    default: o_st_wdata = {4'd0, r_len[11:8]};
                endcase
                if (r_cnt[1:0] == 2'd3) begin
                    n_app = r_app + PW'(4); n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + SW'(1);
                end
            end
            S_FWALK: begin
                if (!hdr_fits) n_state = r_fret;
                else begin n_hb = '0; n_hret = S_FHDR; n_state = S_HDR; end
            end
            S_FHDR: begin
                if (hdr_key == UNUSED_KEY || !rec_ok) begin
                    n_state = r_fret;
                end else begin
                    if (hdr_key == r_tgt) begin
                        n_found = 1'b1; n_at = r_pos; n_at_len = hdr_len;
                    end
                    n_pos = rec_end[PW-1:0]; n_state = S_FWALK;
                end
            end
            S_RDONE: begin
                if (!r_found) begin
                    n_status = ST_NO_RECORD; n_state = S_FIN;
                end else if (16'(r_off) >= r_at_len) begin
                    n_status = ST_ERROR; n_state = S_FIN;
                end else begin
                    n_state = S_RRD;
                end
            end
            S_RRD: begin
                o_raddr = rd_byte[AW-1:0]; n_state = S_RQ;
            end
            S_RQ: begin
                n_dout = i_st_q; n_state = S_FIN;
            end
            S_CCOPY: begin
                o_raddr = r_cnt[AW-1:0];
                if (r_cnt != '0) o_sc_we = 1'b1;
                if (r_cnt == MEM_S) begin
                    n_cnt = '0; n_app = '0; n_pos = '0; n_n = '0; n_src = 1'b1;
                    n_eret = S_CWALK; n_state = S_ERASE;
                end else begin
                    n_cnt = r_cnt + SW'(1);
                end
            end
            S_CWALK: begin
                if (!hdr_fits) begin
                    n_i = '0; n_state = S_CNEXT;
                end else begin
                    n_hb = '0; n_hret = S_CHDR; n_state = S_HDR;
                end
            end
            S_CHDR: begin
                if (hdr_key == UNUSED_KEY || !rec_ok) begin
                    n_i = '0; n_state = S_CNEXT;
                end else begin
                    n_pos = rec_end[PW-1:0];
                    if (hdr_key == r_key) n_state = S_CWALK;
                    else begin n_j = '0; n_state = S_CSRCH; end
                end
            end
            S_CSRCH: begin
                if (r_j == r_n) begin
                    if (r_n != SLOT_N) begin
                        o_kl_we = 1'b1; n_n = r_n + NW'(1);
                    end
                    n_state = S_CWALK;
                end else begin
                    n_state = S_CSCMP;
                end
            end
            S_CSCMP: begin
                if (i_kl_q == hdr_key) n_state = S_CWALK;
                else begin n_j = r_j + NW'(1); n_state = S_CSRCH; end
            end
            S_CNEXT: begin
                o_kl_raddr = r_i[KW-1:0];
                if (r_i == r_n) n_state = S_WCHK;
                else n_state = S_CKEY;
            end
            S_CKEY: begin
                n_tgt = i_kl_q; n_found = 1'b0; n_pos = '0;
                n_fret = S_CCP0; n_state = S_FWALK;
            end
            S_CCP0: begin
                if (!r_found) begin
                    n_i = r_i + NW'(1); n_state = S_CNEXT;
                end else if (SW'(r_app) + at_size > MEM_S) begin
                    n_state = S_WCHK;
                end else begin
                    n_cnt = '0; n_state = S_CCPY;
                end
            end
            S_CCPY: begin
                o_raddr = rd_cpy[AW-1:0];
                o_st_waddr = wr_cpy[AW-1:0];
                o_st_wdata = i_sc_q;
                if (r_cnt != '0) o_st_we = 1'b1;
                if (r_cnt == at_size) begin
                    n_app = r_app + at_size[PW-1:0];
                    n_i = r_i + NW'(1); n_state = S_CNEXT;
                end else begin
                    n_cnt = r_cnt + SW'(1);
                end
            end
            S_FIN: begin
                if (!r_ovalid || i_res_ready) begin
                    n_ovalid = 1'b1;
                    n_res.status = r_status;
                    n_res.data_out = r_dout;
                    n_res.write_pos = 13'(r_app);
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ERASE; r_eret <= S_IDLE; r_hret <= S_IDLE; r_fret <= S_IDLE;
            r_cnt <= '0; r_app <= '0; r_ovalid <= 1'b0; r_hb <= '0; r_src <= 1'b0;
            r_cmpd <= 1'b0; r_n <= '0; r_i <= '0; r_j <= '0; r_found <= 1'b0;
            r_pos <= '0;
        end else begin
            r_state <= n_state; r_eret <= n_eret; r_hret <= n_hret; r_fret <= n_fret;
            r_cnt <= n_cnt; r_app <= n_app; r_ovalid <= n_ovalid; r_hb <= n_hb;
            r_src <= n_src; r_cmpd <= n_cmpd; r_n <= n_n; r_i <= n_i; r_j <= n_j;
            r_found <= n_found; r_pos <= n_pos;
        end
        r_at <= n_at; r_hdr <= n_hdr; r_key <= n_key; r_tgt <= n_tgt;
        r_at_len <= n_at_len; r_len <= n_len; r_off <= n_off;
        r_status <= n_status; r_dout <= n_dout; r_res <= n_res;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = r_ovalid;
    assign o_res       = r_res;
    assign o_hdr_key   = hdr_key;
endmodule

FILE: rtl/core/log_structured_record_store.sv
`timescale 1ns / 1ps
// Top level of the log-structured record store.
// Depends on lsrs_pkg, lsrs_ram and lsrs_ctrl.
//
// channel  dir  content
// s_axis   in   tuser: cmd; tdata: key, length, data_in, offset
// m_axis   out  tdata: status, data_out, write_pos
//
// Write byte writes the store directly; erase clears the whole store byte by byte.
// Mount and read byte walk the record headers one by one, four header bytes each.
// Write start that must compact: copy of the store to scratch and erase, one header walk
// with a key-list search per record, one walk per listed key, and the bytes moved.
// After reset the store is cleared to 0xFF; s_axis_tready stays low until that is done.
// The result register frees the sequencer while m_axis is stalled, until the next result is ready.
module log_structured_record_store #(
    parameter int MEM_BYTES = 4096,
    parameter int KEY_SLOTS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // key[15:0], length[27:16], data_in[35:28], offset[47:36]
    input  logic [2:0]  s_axis_tuser,   // cmd[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // status[2:0], data_out[10:3], write_pos[23:11]
);
    import lsrs_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    localparam int KW = $clog2(KEY_SLOTS);

    t_result       res;
    logic          st_we, sc_we, kl_we;
    logic [AW-1:0] st_waddr, sc_waddr, raddr;
    logic [7:0]    st_wdata, st_q, sc_q;
    logic [KW-1:0] kl_waddr, kl_raddr;
    logic [15:0]   kl_q;
    logic [15:0]   res_key_src;

    lsrs_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_store (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_waddr), .i_wdata(st_wdata),
        .i_raddr(raddr), .o_rdata(st_q)
    );

    lsrs_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_scratch (
        .i_clk(i_clk), .i_we(sc_we), .i_waddr(sc_waddr), .i_wdata(st_q),
        .i_raddr(raddr), .o_rdata(sc_q)
    );

    lsrs_ram #(.WIDTH(16), .DEPTH(KEY_SLOTS)) u_keys (
        .i_clk(i_clk), .i_we(kl_we), .i_waddr(kl_waddr), .i_wdata(res_key_src),
        .i_raddr(kl_raddr), .o_rdata(kl_q)
    );

    lsrs_ctrl #(.MEM_BYTES(MEM_BYTES), .KEY_SLOTS(KEY_SLOTS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_cmd(s_axis_tuser), .i_key(s_axis_tdata[15:0]),
        .i_length(s_axis_tdata[27:16]), .i_data_in(s_axis_tdata[35:28]),
        .i_offset(s_axis_tdata[47:36]),
        .o_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready), .o_res(res),
        .o_st_we(st_we), .o_st_waddr(st_waddr), .o_st_wdata(st_wdata),
        .o_raddr(raddr), .i_st_q(st_q),
        .o_sc_we(sc_we), .o_sc_waddr(sc_waddr), .i_sc_q(sc_q),
        .o_kl_we(kl_we), .o_kl_waddr(kl_waddr), .o_kl_raddr(kl_raddr),
        .i_kl_q(kl_q), .o_hdr_key(res_key_src)
    );

    assign m_axis_tdata = {res.write_pos, res.data_out, res.status};
endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for log_structured_record_store: directed and random commands
// on s_axis, results on m_axis compared against an in-bench byte-level store predictor.
// Depends on lsrs_pkg and the record store RTL.
module tb_top;
    import lsrs_pkg::*;

    localparam int MEM       = 4096;
    localparam int SLOTS     = 1024;
    localparam int HDR       = 4;
    localparam int CYC_LIMIT = 40000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // key[15:0], length[27:16], data_in[35:28], offset[47:36]
    logic [2:0]  s_axis_tuser;   // cmd[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // status[2:0], data_out[10:3], write_pos[23:11]

    log_structured_record_store uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    logic [7:0]  store_img [MEM];
    logic [7:0]  scratch_img [MEM];
    logic [15:0] seen_keys [SLOTS];
    int          wr_pos;

    t_result     pending_results [$];
    int          fail_cnt;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          rx_hold_cycles;
    int          cycle_cnt;

    logic [15:0] key_pool [8] = '{16'h0000, 16'h0001, 16'h0002, 16'h0003,
                                  16'h8000, 16'h7FFF, 16'hFFFE, 16'h1234};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] mem_byte(input bit from_scratch, input int a);
        return from_scratch ? scratch_img[a] : store_img[a];
    endfunction

    function automatic bit read_hdr(input bit from_scratch, input int pos,
                                    output int k, output int len);
        k = 0;
        len = 0;
        if (pos + HDR > MEM) return 1'b0;
        k   = {mem_byte(from_scratch, pos + 1), mem_byte(from_scratch, pos)};
        len = {mem_byte(from_scratch, pos + 3), mem_byte(from_scratch, pos + 2)};
        return 1'b1;
    endfunction

    function automatic bit record_ok(input bit from_scratch, input int pos,
                                     output int k, output int len);
        if (!read_hdr(from_scratch, pos, k, len)) return 1'b0;
        if (k == UNUSED_KEY) return 1'b0;
        return pos + HDR + len <= MEM;
    endfunction

    function automatic bit latest_copy(input bit from_scratch, input int k,
                                       output int at, output int at_len);
        int  pos;
        int  rk;
        int  rl;
        bit  found;
        pos = 0;
        found = 1'b0;
        at = 0;
        at_len = 0;
        while (record_ok(from_scratch, pos, rk, rl)) begin
            if (rk == k) begin
                at = pos;
                at_len = rl;
                found = 1'b1;
            end
            pos += HDR + rl;
        end
        return found;
    endfunction

    function automatic void compact_store(input int incoming);
        int pos;
        int rk;
        int rl;
        int n;
        int i;
        int at;
        int len;
        bit dup;
        for (int a = 0; a < MEM; a++) begin
            scratch_img[a] = store_img[a];
            store_img[a] = ERASED_BYTE;
        end
        wr_pos = 0;
        pos = 0;
        n = 0;
        while (record_ok(1'b1, pos, rk, rl)) begin
            pos += HDR + rl;
            if (rk != incoming) begin
                dup = 1'b0;
                for (i = 0; i < n; i++) if (seen_keys[i] == rk) dup = 1'b1;
                if (!dup && n < SLOTS) begin
                    seen_keys[n] = rk[15:0];
                    n++;
                end
            end
        end
        for (i = 0; i < n; i++) begin
            if (latest_copy(1'b1, seen_keys[i], at, len)) begin
                if (wr_pos + HDR + len > MEM) break;
                for (int b = 0; b < HDR + len; b++) store_img[wr_pos + b] = scratch_img[at + b];
                wr_pos += HDR + len;
            end
        end
    endfunction

    function automatic t_result predict_cmd(input logic [2:0] cmd, input logic [15:0] key,
                                            input logic [11:0] len, input logic [7:0] din,
                                            input logic [11:0] off);
        t_result r;
        int pos;
        int rk;
        int rl;
        int at;
        int alen;
        r.status = ST_OK;
        r.data_out = 8'h00;
        case (cmd)
            CMD_ERASE: begin
                for (int a = 0; a < MEM; a++) store_img[a] = ERASED_BYTE;
            end
            CMD_MOUNT: begin
                pos = 0;
                r.status = ST_ERROR;
                while (read_hdr(1'b0, pos, rk, rl)) begin
                    if (rk == UNUSED_KEY) begin
                        wr_pos = pos;
                        r.status = (pos == 0) ? ST_NO_RECORD : ST_OK;
                        break;
                    end
                    if (pos + HDR + rl > MEM) break;
                    pos += HDR + rl;
                end
            end
            CMD_WSTART: begin
                if (key == UNUSED_KEY) begin
                    r.status = ST_WRONG_KEY;
                end else begin
                    if (HDR + int'(len) > MEM - wr_pos) compact_store(key);
                    if (HDR + int'(len) > MEM - wr_pos) begin
                        r.status = ST_FULL;
                    end else begin
                        store_img[wr_pos]     = key[7:0];
                        store_img[wr_pos + 1] = key[15:8];
                        store_img[wr_pos + 2] = len[7:0];
                        store_img[wr_pos + 3] = {4'h0, len[11:8]};
                        wr_pos += HDR;
                    end
                end
            end
            CMD_WBYTE: begin
                if (wr_pos < MEM) begin
                    store_img[wr_pos] = din;
                    wr_pos++;
                end else begin
                    r.status = ST_FULL;
                end
            end
            CMD_RBYTE: begin
                if (key == UNUSED_KEY) r.status = ST_WRONG_KEY;
                else if (!latest_copy(1'b0, key, at, alen)) r.status = ST_NO_RECORD;
                else if (int'(off) >= alen) r.status = ST_ERROR;
                else r.data_out = store_img[at + HDR + off];
            end
            default: r.status = ST_ERROR;
        endcase
        r.write_pos = wr_pos[12:0];
        return r;
    endfunction

    task automatic send_cmd(input logic [2:0] cmd, input logic [15:0] key,
                            input logic [11:0] len = 12'd0, input logic [7:0] din = 8'd0,
                            input logic [11:0] off = 12'd0);
        @(negedge i_clk);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        s_axis_tuser  = cmd;
        s_axis_tdata  = {off, din, len, key};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(predict_cmd(cmd, key, len, din, off));
    endtask

    // receiver: random stall, or a long hold when requested
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                m_axis_tready = 1'b0;
                rx_hold_cycles--;
            end else begin
                m_axis_tready = ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata);
            if (pending_results.size() == 0) begin
                $error("unexpected result %h", m_axis_tdata);
                fail_cnt++;
            end else begin
                exp_r = pending_results.pop_front();
                if (got.status !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, got.status);
                    fail_cnt++;
                end
                if (got.data_out !== exp_r.data_out) begin
                    $error("data_out: expected %0h, got %0h", exp_r.data_out, got.data_out);
                    fail_cnt++;
                end
                if (got.write_pos !== exp_r.write_pos) begin
                    $error("write_pos: expected %0d, got %0d", exp_r.write_pos, got.write_pos);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt > CYC_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic test_directed();
        send_cmd(CMD_RBYTE, 16'd5);
        send_cmd(CMD_MOUNT, 16'd0);
        send_cmd(CMD_WSTART, UNUSED_KEY, 12'd2);
        send_cmd(CMD_RBYTE, UNUSED_KEY);
        send_cmd(CMD_WSTART, 16'h0000, 12'd3);
        send_cmd(CMD_WBYTE, 16'd0, 12'd0, 8'h00);
        send_cmd(CMD_WBYTE, 16'd0, 12'd0, 8'hFF);
        send_cmd(CMD_WBYTE, 16'd0, 12'd0, 8'hA5);
        send_cmd(CMD_RBYTE, 16'h0000, 12'd0, 8'd0, 12'd0);
        send_cmd(CMD_RBYTE, 16'h0000, 12'd0, 8'd0, 12'd2);
        send_cmd(CMD_RBYTE, 16'h0000, 12'd0, 8'd0, 12'd3);
        send_cmd(CMD_RBYTE, 16'h0000, 12'd0, 8'd0, 12'hFFF);
        send_cmd(CMD_MOUNT, 16'd0);
        send_cmd(CMD_WSTART, 16'hFFFE, 12'd1);
        send_cmd(CMD_WBYTE, 16'd0, 12'd0, 8'h5A);
        send_cmd(3'd5, 16'hFFFF, 12'hFFF, 8'hFF, 12'hFFF);
        send_cmd(3'd6, 16'd0);
        send_cmd(3'd7, 16'd0);
        // compaction that still leaves no room
        send_cmd(CMD_WSTART, 16'h0001, 12'd4092);
        send_cmd(CMD_ERASE, 16'd0);
        send_cmd(CMD_MOUNT, 16'd0);
        // record that ends exactly at the end of the store
        send_cmd(CMD_WSTART, 16'h0002, 12'd4092);
        send_cmd(CMD_MOUNT, 16'd0);
        send_cmd(CMD_WSTART, 16'h0003, 12'hFFF);
        send_cmd(CMD_ERASE, 16'd0);
        send_cmd(CMD_MOUNT, 16'd0);
    endtask

    task automatic test_random(input int n_items);
        int          r;
        logic [15:0] k;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            k = key_pool[$urandom_range(0, 7)];
            if (r < 40 || r >= 90) begin
                send_cmd(CMD_WBYTE, 16'($urandom), 12'($urandom), 8'($urandom), 12'($urandom));
            end else if (r < 55) begin
                send_cmd(CMD_WSTART, k, 12'($urandom_range(0, 24)));
            end else if (r < 75) begin
                send_cmd(CMD_RBYTE, k, 12'd0, 8'd0,
                         ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 24)));
            end else if (r < 79) begin
                send_cmd(CMD_WSTART, k, 12'($urandom_range(3000, 4095)));
            end else if (r < 83) begin
                send_cmd(CMD_MOUNT, 16'($urandom));
            end else if (r < 84) begin
                send_cmd(CMD_ERASE, 16'($urandom));
            end else if (r < 86) begin
                send_cmd(CMD_RBYTE, 16'($urandom), 12'd0, 8'd0, 12'($urandom));
            end else if (r < 88) begin
                send_cmd(CMD_WSTART, 16'($urandom), 12'($urandom_range(0, 40)));
            end else begin
                send_cmd(3'($urandom_range(5, 7)), 16'($urandom), 12'($urandom));
            end
        end
    endtask

    task automatic test_backpressure();
        rx_hold_cycles = 400;
        send_cmd(CMD_WSTART, 16'h0042, 12'd24);
        for (int i = 0; i < 24; i++) send_cmd(CMD_WBYTE, 16'd0, 12'd0, 8'($urandom));
        send_cmd(CMD_RBYTE, 16'h0042, 12'd0, 8'd0, 12'd23);
    endtask

    initial begin
        fail_cnt = 0;
        rx_hold_cycles = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        wr_pos = 0;
        for (int a = 0; a < MEM; a++) store_img[a] = ERASED_BYTE;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_ERASE;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        tx_idle_pct = 8;
        rx_idle_pct = 74;
        test_random(180);
        tx_idle_pct = 74;
        rx_idle_pct = 8;
        test_random(180);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_backpressure();
        test_random(180);

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
